### rtl/iut_pkg.sv
// ----------------------------------------------------------------------------
// iut_pkg
// Shared widths, request and status codes, and the command and status
// bundles that run between the interval union controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package iut_pkg;

    localparam int MAX_ENDPOINTS_DEF = 64;

    localparam int VAL_W  = 31;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_SCAN,
        OP_SHIFT_INIT,
        OP_SHIFT,
        OP_INS_S,
        OP_INS_E,
        OP_FIX_S,
        OP_FIX_E,
        OP_MOVE,
        OP_SUM,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              set_status;
        logic [STAT_W-1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             start_gt_end;
        logic             walk_done;
        logic             insert_needed;
        logic             store_full;
        logic             out_free;
    } stat_t;

endpackage

`default_nettype wire

### rtl/interval_union_tracker.sv
// ----------------------------------------------------------------------------
// interval_union_tracker
// Union of added time intervals kept as a sorted endpoint list; handles
// clear, add (lazy merge) and query of total covered length.
// ----------------------------------------------------------------------------
//  channel   flow  handshake              beat fields
//  request   in    req_valid / req_stall  req_type, interval_start, interval_end
//  result    out   res_valid / res_stall  covered_total, status
//
//  One request at a time, one result per request. An add is rejected,
//  dropped when the list is full, inserted as a new pair, or merged.
//  Reset clears the endpoint count; memory contents are not cleared.
//  A result waiting under res_stall does not block the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_union_tracker
#(
    parameter int MAX_ENDPOINTS = iut_pkg::MAX_ENDPOINTS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [iut_pkg::REQ_W-1:0]     req_type,
    input  wire logic [iut_pkg::VAL_W-1:0]     interval_start,
    input  wire logic [iut_pkg::VAL_W-1:0]     interval_end,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic [iut_pkg::VAL_W-1:0]          covered_total,
    output logic [iut_pkg::STAT_W-1:0]         status
);
    import iut_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    iut_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    iut_dpath
    #(
        .MAX_ENDPOINTS (MAX_ENDPOINTS)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .covered_total  (covered_total),
        .status         (status)
    );

endmodule

`default_nettype wire

### rtl/iut_ctrl.sv
// ----------------------------------------------------------------------------
// iut_ctrl
// Request sequencer: decodes the latched request and steps the datapath
// through scan, shift, insert, merge, sum and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module iut_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    output iut_pkg::cmd_t       cmd,
    input  wire iut_pkg::stat_t stat
);
    import iut_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DISPATCH = 12'b0000_0000_0010,
        S_SCAN     = 12'b0000_0000_0100,
        S_DECIDE   = 12'b0000_0000_1000,
        S_SHIFT    = 12'b0000_0001_0000,
        S_INS_S    = 12'b0000_0010_0000,
        S_INS_E    = 12'b0000_0100_0000,
        S_FIX_S    = 12'b0000_1000_0000,
        S_FIX_E    = 12'b0001_0000_0000,
        S_MOVE     = 12'b0010_0000_0000,
        S_SUM      = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.set_status = 1'b0;
        cmd.status     = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.req == REQ_CLEAR)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_EMIT;
                end
                else if (stat.req == REQ_ADD)
                begin
                    if (stat.start_gt_end)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_REJECT;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (stat.req == REQ_QUERY)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.walk_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.insert_needed && stat.store_full)
                begin
                    // drop the add, list unchanged
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FULL;
                    state_next     = S_EMIT;
                end
                else if (stat.insert_needed)
                begin
                    cmd.op     = OP_SHIFT_INIT;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_FIX_S;
                end
            end
            S_SHIFT:
            begin
                cmd.op = OP_SHIFT;
                if (stat.walk_done)
                begin
                    state_next = S_INS_S;
                end
            end
            S_INS_S:
            begin
                cmd.op     = OP_INS_S;
                state_next = S_INS_E;
            end
            S_INS_E:
            begin
                cmd.op     = OP_INS_E;
                state_next = S_EMIT;
            end
            S_FIX_S:
            begin
                cmd.op     = OP_FIX_S;
                state_next = S_FIX_E;
            end
            S_FIX_E:
            begin
                cmd.op     = OP_FIX_E;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.op = OP_MOVE;
                if (stat.walk_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_SUM:
            begin
                cmd.op = OP_SUM;
                if (stat.walk_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/iut_dpath.sv
// ----------------------------------------------------------------------------
// iut_dpath
// Endpoint memory with one write and one registered read port, walk
// pointer, search results, length accumulator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iut_dpath
#(
    parameter int MAX_ENDPOINTS = iut_pkg::MAX_ENDPOINTS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire iut_pkg::cmd_t                cmd,
    output iut_pkg::stat_t                    stat,
    input  wire logic [iut_pkg::REQ_W-1:0]    req_type,
    input  wire logic [iut_pkg::VAL_W-1:0]    interval_start,
    input  wire logic [iut_pkg::VAL_W-1:0]    interval_end,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output logic [iut_pkg::VAL_W-1:0]         covered_total,
    output logic [iut_pkg::STAT_W-1:0]        status
);
    import iut_pkg::*;

    localparam int AW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
    localparam int CW = $clog2(MAX_ENDPOINTS + 1);

    logic [VAL_W-1:0]  mem [MAX_ENDPOINTS];

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     ptr_reg;
    logic [CW-1:0]     ptr_next;
    logic              pend_reg;
    logic              pend_next;
    logic [AW-1:0]     tag_reg;
    logic [AW-1:0]     tag_next;
    logic              res_valid_reg;

    logic [REQ_W-1:0]  req_reg;
    logic [VAL_W-1:0]  s_reg;
    logic [VAL_W-1:0]  e_reg;
    logic [VAL_W-1:0]  rdata_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic              found_i_reg;
    logic              found_j_reg;
    logic [VAL_W-1:0]  a_reg;
    logic [VAL_W-1:0]  acc_reg;
    logic [STAT_W-1:0] status_reg;
    logic [VAL_W-1:0]  total_reg;
    logic [STAT_W-1:0] res_status_reg;

    logic              advance;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [CW:0]       ptr_inc_ext;
    logic [CW:0]       j_ext;
    logic [CW:0]       count_ext;

    assign ptr_inc_ext = {1'b0, ptr_reg} + (CW+1)'(1);
    assign j_ext       = {1'b0, j_reg};
    assign count_ext   = {1'b0, count_reg};

    always_comb
    begin
        advance   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = s_reg;
        ptr_next  = ptr_reg;
        tag_next  = tag_reg;
        pend_next = 1'b0;
        unique case (cmd.op) inside
            OP_LOAD:
            begin
                ptr_next = '0;
            end
            OP_SCAN, OP_SUM:
            begin
                advance = (ptr_reg < count_reg);
                rd_en   = advance;
                rd_addr = ptr_reg[AW-1:0];
                if (advance)
                begin
                    ptr_next  = ptr_reg + CW'(1);
                    tag_next  = ptr_reg[AW-1:0];
                    pend_next = 1'b1;
                end
            end
            OP_SHIFT_INIT:
            begin
                ptr_next = count_reg;
            end
            OP_SHIFT:
            begin
                // walk down from the top, each entry moves up by one pair
                advance = (ptr_reg > i_reg);
                rd_en   = advance;
                rd_addr = AW'(ptr_reg - CW'(1));
                if (advance)
                begin
                    ptr_next  = ptr_reg - CW'(1);
                    tag_next  = rd_addr;
                    pend_next = 1'b1;
                end
                wr_en   = pend_reg;
                wr_addr = tag_reg + AW'(2);
                wr_data = rdata_reg;
            end
            OP_INS_S:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg[AW-1:0];
                wr_data = s_reg;
            end
            OP_INS_E:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg[AW-1:0] + AW'(1);
                wr_data = e_reg;
            end
            OP_FIX_S:
            begin
                wr_en    = !i_reg[0] && (i_reg < count_reg);
                wr_addr  = i_reg[AW-1:0];
                wr_data  = s_reg;
                ptr_next = i_reg;
            end
            OP_FIX_E:
            begin
                wr_en   = !j_reg[0] && (j_reg != '0) && ((j_reg - CW'(1)) < count_reg);
                wr_addr = AW'(j_reg - CW'(1));
                wr_data = e_reg;
            end
            OP_MOVE:
            begin
                // close each covered gap: odd entry takes the next start
                advance = (ptr_inc_ext < j_ext);
                rd_en   = advance && ptr_reg[0] && (ptr_inc_ext < count_ext);
                rd_addr = AW'(ptr_reg + CW'(1));
                if (advance)
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
                if (rd_en)
                begin
                    tag_next  = ptr_reg[AW-1:0];
                    pend_next = 1'b1;
                end
                wr_en   = pend_reg;
                wr_addr = tag_reg;
                wr_data = rdata_reg;
            end
            default:
            begin
                advance = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.op == OP_CLEAR)
        begin
            count_next = '0;
        end
        else if (cmd.op == OP_INS_E)
        begin
            count_next = count_reg + CW'(2);
        end
    end

    assign stat.req           = req_reg;
    assign stat.start_gt_end  = (s_reg > e_reg);
    assign stat.walk_done     = !advance && !pend_reg;
    assign stat.insert_needed = !i_reg[0] && (i_reg == j_reg);
    assign stat.store_full    = ((count_ext + (CW+1)'(2)) > (CW+1)'(MAX_ENDPOINTS));
    assign stat.out_free      = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            tag_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            tag_reg   <= tag_next;
            if (cmd.op == OP_EMIT)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            req_reg     <= req_type;
            s_reg       <= interval_start;
            e_reg       <= interval_end;
            i_reg       <= count_reg;
            j_reg       <= count_reg;
            found_i_reg <= 1'b0;
            found_j_reg <= 1'b0;
            acc_reg     <= '0;
            status_reg  <= ST_OK;
        end
        else
        begin
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            if (cmd.op == OP_SCAN && pend_reg)
            begin
                // first entry not below each bound
                if (!found_i_reg && !(s_reg > rdata_reg))
                begin
                    i_reg       <= CW'(tag_reg);
                    found_i_reg <= 1'b1;
                end
                if (!found_j_reg && !(e_reg > rdata_reg))
                begin
                    j_reg       <= CW'(tag_reg);
                    found_j_reg <= 1'b1;
                end
            end
            if (cmd.op == OP_SUM && pend_reg)
            begin
                if (!tag_reg[0])
                begin
                    a_reg <= rdata_reg;
                end
                else if (rdata_reg > a_reg)
                begin
                    acc_reg <= acc_reg + (rdata_reg - a_reg);
                end
            end
        end
        if (cmd.op == OP_EMIT)
        begin
            total_reg      <= acc_reg;
            res_status_reg <= status_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign covered_total = total_reg;
    assign status        = res_status_reg;

endmodule

`default_nettype wire

### rtl/iut_checker.sv
// ----------------------------------------------------------------------------
// iut_checker
// Port-level checks for the interval union tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iut_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_stall,
    input wire logic [iut_pkg::REQ_W-1:0]     req_type,
    input wire logic [iut_pkg::VAL_W-1:0]     interval_start,
    input wire logic [iut_pkg::VAL_W-1:0]     interval_end,
    input wire logic                          res_valid,
    input wire logic                          res_stall,
    input wire logic [iut_pkg::VAL_W-1:0]     covered_total,
    input wire logic [iut_pkg::STAT_W-1:0]    status
);
    import iut_pkg::*;

    // hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(covered_total) && $stable(status))
        else $error("stalled result beat changed");

    // one request in flight: stall right after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while busy");

    // a dropped or rejected add carries no length
    a_err_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_FULL || status == ST_REJECT) |-> covered_total == '0)
        else $error("error status with nonzero total");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status == ST_OK || status == ST_FULL || status == ST_REJECT))
        else $error("unused status code");

endmodule

bind interval_union_tracker iut_checker u_iut_checker (.*);

`default_nettype wire
